>>> hw/rtl/spn_pkg.sv
// Shared types, constants and round functions for the 64-bit SPN encrypt core.
`timescale 1ns / 1ps

package spn_pkg;

  // Number of S-box rounds after the key whitening (legal range 1 to 7).
  localparam int ROUND_COUNT = 4;
  localparam int BLOCK_W     = 64;
  localparam int NIBBLES     = BLOCK_W / 4;

  // Fixed 4-bit substitution box.
  localparam logic [3:0] SBOX [16] = '{
    4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
    4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
  };

  // One word in flight between pipeline stages.
  typedef struct packed {
    logic               valid;
    logic [BLOCK_W-1:0] data;
  } spn_stage_t;

  // Per-stage round control: which operations the stage applies.
  typedef struct packed {
    logic               bypass_sbox;
    logic               skip_perm;
    logic [BLOCK_W-1:0] round_key;
  } spn_round_ctrl_t;

  // Substitute all sixteen nibbles through the S-box.
  function automatic logic [BLOCK_W-1:0] sbox_layer(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int k = 0; k < NIBBLES; k++) begin
      r[k*4 +: 4] = SBOX[v[k*4 +: 4]];
    end
    return r;
  endfunction

  // Bit permutation: MSB-numbered bit i moves to (i mod 4)*16 + i/4.
  function automatic logic [BLOCK_W-1:0] spread_bits(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int i = 0; i < BLOCK_W; i++) begin
      r[BLOCK_W-1-((i % 4) * 16 + (i / 4))] = v[BLOCK_W-1-i];
    end
    return r;
  endfunction

  // Round key: master key rotated left by whole bytes.
  function automatic logic [BLOCK_W-1:0] round_key(input logic [BLOCK_W-1:0] key,
                                                  input logic [2:0] rnd);
    logic [2*BLOCK_W-1:0] dbl;
    logic [5:0]           sh;
    sh  = {rnd, 3'b000};
    dbl = {key, key} << sh;
    return dbl[2*BLOCK_W-1 -: BLOCK_W];
  endfunction

endpackage

>>> hw/rtl/spn_if.sv
// Valid/ready channel interfaces for plaintext and ciphertext words.
`timescale 1ns / 1ps

interface spn_pt_if;
  logic        valid;
  logic        ready;
  logic [63:0] plaintext;

  modport source (output valid, output plaintext, input ready);
  modport sink   (input valid, input plaintext, output ready);
endinterface

interface spn_ct_if;
  logic        valid;
  logic        ready;
  logic [63:0] ciphertext;

  modport source (output valid, output ciphertext, input ready);
  modport sink   (input valid, input ciphertext, output ready);
endinterface

>>> hw/rtl/spn_round.sv
// One registered pipeline stage: optional S-box layer, optional permutation, key XOR.
`timescale 1ns / 1ps

module spn_round (
  input  logic                     clk,
  input  logic                     rst_n,
  input  spn_pkg::spn_round_ctrl_t ctrl,
  input  spn_pkg::spn_stage_t      up,
  output logic                     up_ready,
  output spn_pkg::spn_stage_t      dn,
  input  logic                     dn_ready
);
  import spn_pkg::*;

  logic               valid_r;
  logic               valid_nxt;
  logic [BLOCK_W-1:0] data_r;
  logic [BLOCK_W-1:0] data_nxt;
  logic [BLOCK_W-1:0] subbed;
  logic [BLOCK_W-1:0] permuted;

  // Round datapath.
  always_comb begin
    subbed   = ctrl.bypass_sbox ? up.data : sbox_layer(up.data);
    permuted = ctrl.skip_perm ? subbed : spread_bits(subbed);
    data_nxt = permuted ^ ctrl.round_key;
  end

  // The stage takes a word when it is empty or its word leaves this cycle.
  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up.valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn.valid = valid_r;
  assign dn.data  = data_r;

endmodule

>>> hw/rtl/spn_block_cipher_64bit_encrypt_core.sv
// Top level of the 64-bit SPN encrypt core: key register and round pipeline.
// One register stage per round plus one for whitening.
// Throughput: one word per cycle while the output is not stalled.
// A stalled output holds every full stage up to the first empty one; the input keeps accepting while stages are free.
// Reset (rst_n low, synchronous) empties the pipeline and clears the key to zero.
`timescale 1ns / 1ps

module spn_block_cipher_64bit_encrypt_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  spn_pt_if.sink      in_ch,
  spn_ct_if.source    out_ch
);
  import spn_pkg::*;

  logic [BLOCK_W-1:0] key_r;
  logic [BLOCK_W-1:0] key_nxt;

  spn_stage_t      stg    [ROUND_COUNT+2];
  logic            stg_rdy[ROUND_COUNT+2];
  spn_round_ctrl_t ctrl   [ROUND_COUNT+1];

  // Key register.
  assign key_nxt = cfg_we ? cfg_wdata : key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  // Input word enters stage 0.
  assign stg[0].valid = in_ch.valid;
  assign stg[0].data  = in_ch.plaintext;
  assign in_ch.ready  = stg_rdy[0];

  // Stage 0 whitens with the plain key; the last round has no permutation.
  for (genvar k = 0; k <= ROUND_COUNT; k++) begin : g_stage
    assign ctrl[k].bypass_sbox = (k == 0);
    assign ctrl[k].skip_perm   = (k == 0) || (k == ROUND_COUNT);
    assign ctrl[k].round_key   = round_key(key_r, 3'(k));

    spn_round u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl[k]),
      .up       (stg[k]),
      .up_ready (stg_rdy[k]),
      .dn       (stg[k+1]),
      .dn_ready (stg_rdy[k+1])
    );
  end

  // Last stage drives the result channel.
  assign out_ch.valid            = stg[ROUND_COUNT+1].valid;
  assign out_ch.ciphertext       = stg[ROUND_COUNT+1].data;
  assign stg_rdy[ROUND_COUNT+1]  = out_ch.ready;

  // An accepted word always lands in the whitening stage.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> stg[1].valid)
    else $error("accepted word did not enter stage 0");

  // With the whitening stage full and blocked and the output stalled, the input accepts nothing.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    stg[1].valid && out_ch.valid && !out_ch.ready
      && $countones({stg[1].valid, stg[ROUND_COUNT+1].valid}) == 2
      && stg_rdy[1] == 1'b0 |-> !in_ch.ready)
    else $error("input ready while first stage is blocked");

  // A held result keeps its value until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.ciphertext))
    else $error("stalled result changed or vanished");

  // Reset leaves the result channel empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the 64-bit SPN encrypt core with a built-in cipher predictor.
`timescale 1ns / 1ps

module tb_top;
  import spn_pkg::*;

  localparam int          ROUNDS       = spn_pkg::ROUND_COUNT;
  localparam int          LATENCY      = ROUNDS + 1;
  localparam int          LIMIT_CYCLES = 400000;
  localparam int          LONG_HOLD    = 80;
  localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

  // The cipher's 4-bit substitution table, indexed by the input nibble.
  localparam logic [3:0] NIBBLE_SUB [16] = '{
    4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
    4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
  };

  // One plaintext word in flight together with the ciphertext it must produce.
  typedef struct {
    logic [63:0] plaintext;
    logic [63:0] ciphertext;
  } pending_block_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [63:0] cfg_wdata;

  spn_pt_if pt_ch ();
  spn_ct_if ct_ch ();

  spn_block_cipher_64bit_encrypt_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (pt_ch),
    .out_ch    (ct_ch)
  );

  pending_block_t cipher_expected [$];
  logic [63:0]    key_shadow;
  bit             src_idle_en;
  bit             sink_stall_en;
  int             long_hold_reqs;
  int             error_count;
  int             blocks_sent;
  int             words_checked;
  int             keys_loaded;
  int             input_stall_cycles;
  int             cycle_count;

  // Clock: 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predict one ciphertext: whitening, then ROUNDS rounds of substitution,
  // bit spreading (all rounds but the last) and a byte-rotated round key.
  function automatic logic [63:0] encrypt_block(input logic [63:0] pt,
                                                input logic [63:0] key);
    logic [63:0] acc;
    logic [63:0] sub;
    logic [63:0] spread;
    logic [63:0] rkey;
    int          sh;
    acc = pt ^ key;
    for (int r = 1; r <= ROUNDS; r++) begin
      for (int k = 0; k < 16; k++) begin
        sub[k*4 +: 4] = NIBBLE_SUB[acc[k*4 +: 4]];
      end
      acc = sub;
      if (r < ROUNDS) begin
        // Bit numbering here counts from the MSB, as the cipher defines it.
        for (int i = 0; i < 64; i++) begin
          spread[63 - ((i % 4) * 16 + (i / 4))] = acc[63 - i];
        end
        acc = spread;
      end
      sh = (r % 8) * 8;
      rkey = (sh == 0) ? key : ((key << sh) | (key >> (64 - sh)));
      acc = acc ^ rkey;
    end
    return acc;
  endfunction

  // Offer one plaintext word, optionally after an idle burst, and record the
  // expected ciphertext at the edge where it is accepted. Valid stays high on return.
  task automatic send_block(input logic [63:0] pt);
    pending_block_t item;
    int             gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      pt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_ch.valid     <= 1'b1;
    pt_ch.plaintext <= pt;
    @(posedge clk);
    while (!pt_ch.ready) @(posedge clk);
    item.plaintext  = pt;
    item.ciphertext = encrypt_block(pt, key_shadow);
    cipher_expected.push_back(item);
    blocks_sent++;
  endtask

  // Stop offering words and wait until every expected ciphertext has come out.
  task automatic drain_pipeline();
    pt_ch.valid <= 1'b0;
    @(posedge clk);
    while (cipher_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Load a new key once the pipeline is empty.
  task automatic load_key(input logic [63:0] key);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_wdata <= key;
    @(posedge clk);
    cfg_we     <= 1'b0;
    key_shadow  = key;
    keys_loaded++;
  endtask

  // Random plaintext: mostly dense, sometimes one-hot, one-cold or a single set nibble.
  function automatic logic [63:0] random_block();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = 64'd1 << $urandom_range(0, 63);
      1: v = 64'hF << (4 * $urandom_range(0, 15));
      2: v = ~(64'd1 << $urandom_range(0, 63));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // Directed plaintexts under the reset key of zero.
  task automatic test_reset_key();
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    send_block(64'h0);
    send_block(ALL_ONES);
    send_block(64'h8000_0000_0000_0001);
    send_block(64'h0000_0000_0000_0001);
    send_block(64'h0123_4567_89AB_CDEF);
    send_block(64'hAAAA_AAAA_AAAA_AAAA);
    send_block(64'h5555_5555_5555_5555);
    send_block(64'hF0F0_F0F0_F0F0_F0F0);
  endtask

  // Directed plaintexts under the key extremes and an irregular key.
  task automatic test_key_extremes();
    load_key(ALL_ONES);
    send_block(64'h0);
    send_block(ALL_ONES);
    send_block(64'h8000_0000_0000_0000);
    send_block(64'h0123_4567_89AB_CDEF);
    send_block(64'hFEDC_BA98_7654_3210);
    load_key(64'h0123_4567_89AB_CDEF);
    send_block(64'h0);
    send_block(ALL_ONES);
    send_block(64'h0123_4567_89AB_CDEF);
    load_key(64'h8000_0000_0000_0001);
    send_block(64'h0);
    send_block(64'h8000_0000_0000_0001);
    load_key(64'h0);
    send_block(ALL_ONES);
    send_block(64'h1);
  endtask

  // Random plaintexts under random keys, with idling on both sides in
  // varying combinations, including stretches where one side never idles.
  task automatic test_random_traffic();
    logic [63:0] key;
    for (int phase = 0; phase < 6; phase++) begin
      key = (phase == 3) ? (64'd1 << $urandom_range(0, 63)) : {$urandom, $urandom};
      load_key(key);
      src_idle_en   = (phase % 3) != 2;
      sink_stall_en = (phase % 3) != 1;
      for (int n = 0; n < 220; n++) begin
        send_block(random_block());
      end
    end
  endtask

  // Hold the output off for a long stretch while words keep coming, so the
  // pipeline fills and the input stalls.
  task automatic test_backpressure_fill();
    load_key({$urandom, $urandom});
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    long_hold_reqs++;
    for (int n = 0; n < 40; n++) begin
      send_block(random_block());
    end
  endtask

  // Short bursts of words, each followed by a pause until all results are out.
  task automatic test_burst_and_drain();
    int burst;
    load_key({$urandom, $urandom});
    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
    for (int b = 0; b < 8; b++) begin
      burst = $urandom_range(1, 20);
      for (int n = 0; n < burst; n++) begin
        send_block(random_block());
      end
      drain_pipeline();
    end
  endtask

  // Full-rate streaming with no idling at either end.
  task automatic test_streaming();
    load_key({$urandom, $urandom});
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    for (int n = 0; n < 300; n++) begin
      send_block(random_block());
    end
  endtask

  // Result sink: random stall bursts, plus one long hold on request.
  initial begin
    int sink_hold;
    int long_hold_seen;
    sink_hold      = 0;
    long_hold_seen = 0;
    ct_ch.ready   <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_reqs != long_hold_seen) begin
        long_hold_seen = long_hold_reqs;
        sink_hold      = LONG_HOLD;
        ct_ch.ready   <= 1'b0;
      end else if (sink_hold > 0) begin
        sink_hold--;
        ct_ch.ready <= 1'b0;
      end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
        sink_hold    = $urandom_range(0, 13);
        ct_ch.ready <= 1'b0;
      end else begin
        ct_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted ciphertext word with the oldest expectation.
  always @(posedge clk) begin
    pending_block_t item;
    if (rst_n) begin
      if (pt_ch.valid && !pt_ch.ready) input_stall_cycles++;
      if (ct_ch.valid && ct_ch.ready) begin
        words_checked++;
        if (cipher_expected.size() == 0) begin
          error_count++;
          $display("%0t: unexpected word: expected none, actual ciphertext %h",
                   $time, ct_ch.ciphertext);
        end else begin
          item = cipher_expected.pop_front();
          if (ct_ch.ciphertext !== item.ciphertext) begin
            error_count++;
            $display("%0t: ciphertext mismatch for plaintext %h: expected %h, actual %h",
                     $time, item.plaintext, item.ciphertext, ct_ch.ciphertext);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
        $display("%0t: timeout after %0d cycles, %0d words still expected",
                 $time, cycle_count, cipher_expected.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    key_shadow         = 64'h0;
    src_idle_en        = 1'b0;
    sink_stall_en      = 1'b0;
    long_hold_reqs     = 0;
    error_count        = 0;
    blocks_sent        = 0;
    words_checked      = 0;
    keys_loaded        = 0;
    input_stall_cycles = 0;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 64'h0;
    pt_ch.valid       <= 1'b0;
    pt_ch.plaintext   <= 64'h0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_key();
    test_key_extremes();
    test_random_traffic();
    test_backpressure_fill();
    test_burst_and_drain();
    test_streaming();

    drain_pipeline();
    if (cipher_expected.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected words never arrived", $time, cipher_expected.size());
    end
    $display("Encrypted %0d plaintext words under %0d loaded keys; %0d ciphertext words checked.",
             blocks_sent, keys_loaded, words_checked);
    $display("Input backpressure seen for %0d cycles; %0d mismatches.",
             input_stall_cycles, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> spn_block_cipher_64bit_encrypt_core.f
hw/rtl/spn_pkg.sv
hw/rtl/spn_if.sv
hw/rtl/spn_round.sv
hw/rtl/spn_block_cipher_64bit_encrypt_core.sv
sim/tb_top.sv
